// File: sv/ordered_key_value_table_macros.svh
// Assertion macros for the ordered key/value table.
// Used by the top level only; relies on clk and arst_n in the using scope.
`ifndef ORDERED_KEY_VALUE_TABLE_MACROS_SVH
`define ORDERED_KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OKVT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OKVT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/okvt_pkg.sv
// Shared constants, codes, types and port conversion functions of the
// ordered key/value table. No dependencies.
`default_nettype none

package okvt_pkg;

	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	localparam int POS_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	// Width in which positions and counts are compared.
	localparam int IDX_BITS = (CNT_BITS > 4) ? CNT_BITS : 4;

	typedef enum logic [2:0] {
		ACT_LOOKUP = 3'd0,
		ACT_SET    = 3'd1,
		ACT_UPDATE = 3'd2,
		ACT_DELETE = 3'd3,
		ACT_CLEAR  = 3'd4,
		ACT_READ   = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		STAT_HIT       = 3'd0,
		STAT_INSERTED  = 3'd1,
		STAT_NOT_FOUND = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_RANGE     = 3'd4
	} status_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic                  by_pos;
		logic                  wr_val;
		logic                  ins;
		logic                  shift_en;
		logic [IDX_BITS-1:0]   pos;
		logic [CNT_BITS-1:0]   count;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} cell_bus_t;

	// Outcome of the lowest-match selection over the cell row.
	typedef struct packed {
		logic                  hit;
		logic [CAPACITY-1:0]   onehot;
		logic [CAPACITY-1:0]   after;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		logic [POS_BITS-1:0]   pos;
	} sel_res_t;

	function automatic logic [KEY_BITS-1:0] key_from_port(logic [31:0] p);
		logic [63:0] w;
		w = 64'(p);
		return w[KEY_BITS-1:0];
	endfunction

	function automatic logic [VALUE_BITS-1:0] value_from_port(logic [31:0] p);
		logic [63:0] w;
		w = 64'(p);
		return w[VALUE_BITS-1:0];
	endfunction

	function automatic logic [31:0] key_to_port(logic [KEY_BITS-1:0] k);
		logic [63:0] w;
		w = 64'(k);
		return w[31:0];
	endfunction

	function automatic logic [31:0] value_to_port(logic [VALUE_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/okvt_cell.sv
// One entry cell of the ordered key/value table: key, value and match flag.
// Depends on okvt_pkg.
`default_nettype none

module okvt_cell (
	input  wire logic                            clk,
	input  wire logic [okvt_pkg::POS_BITS-1:0]   idx,
	input  wire okvt_pkg::cell_bus_t             bus,
	input  wire logic                            sel,
	input  wire logic                            after,
	input  wire logic [okvt_pkg::KEY_BITS-1:0]   nb_key,
	input  wire logic [okvt_pkg::VALUE_BITS-1:0] nb_value,
	output logic [okvt_pkg::KEY_BITS-1:0]        key_q,
	output logic [okvt_pkg::VALUE_BITS-1:0]      value_q,
	output logic                                 match_q
);

	logic [okvt_pkg::IDX_BITS-1:0] my_idx;
	logic                          live;

	assign my_idx = okvt_pkg::IDX_BITS'(idx);
	assign live   = my_idx < okvt_pkg::IDX_BITS'(bus.count);

	// Match against the request: by position for reads, by key otherwise.
	always_ff @(posedge clk) begin
		match_q <= live && (bus.by_pos ? (my_idx == bus.pos) : (key_q == bus.key));
	end

	// Shift from the upper neighbor, take a new entry, or overwrite the value.
	always_ff @(posedge clk) begin
		priority if (bus.shift_en && after) begin
			key_q   <= nb_key;
			value_q <= nb_value;
		end else if (bus.ins && (my_idx == okvt_pkg::IDX_BITS'(bus.count))) begin
			key_q   <= bus.key;
			value_q <= bus.value;
		end else if (bus.wr_val && sel) begin
			value_q <= bus.value;
		end
	end

endmodule

`default_nettype wire

// File: sv/okvt_select.sv
// Lowest-match selection over the cell row: one-hot pick, shift mask,
// selected key, value and position. Depends on okvt_pkg.
`default_nettype none

module okvt_select (
	input  wire logic [okvt_pkg::CAPACITY-1:0]   match,
	input  wire logic [okvt_pkg::KEY_BITS-1:0]   keys   [okvt_pkg::CAPACITY],
	input  wire logic [okvt_pkg::VALUE_BITS-1:0] values [okvt_pkg::CAPACITY],
	output okvt_pkg::sel_res_t                   res
);

	logic [okvt_pkg::CAPACITY-1:0] dec;
	logic [okvt_pkg::CAPACITY-1:0] pick;

	// Lowest set bit and the mask of cells at or above it.
	assign dec  = match - okvt_pkg::CAPACITY'(1);
	assign pick = match & ~dec;

	// Gather the picked cell's contents and position.
	always_comb begin
		res        = '0;
		res.hit    = |match;
		res.onehot = pick;
		res.after  = ~(~match & dec);
		for (int i = 0; i < okvt_pkg::CAPACITY; i++) begin
			if (pick[i]) begin
				res.key   = res.key | keys[i];
				res.value = res.value | values[i];
				res.pos   = res.pos | okvt_pkg::POS_BITS'(i);
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/ordered_key_value_table.sv
// Ordered key/value table: controller, row of entry cells and result register.
// Depends on okvt_pkg, okvt_cell, okvt_select and the assertion macro header.
//
// Usage:
//   Requests enter on in_valid/in_ready with action, key_in, value_in and
//   position_in. Each request gives exactly one result on out_valid/out_ready
//   with status, key_out, value_out, position_out and entry_total.
//   Every cell compares its key (or its position, for a read) with the
//   request and registers a match flag; the lowest matching cell is picked
//   and the table is updated at commit. A delete shifts every later cell down
//   by one position in the same commit.
//   The request passes through the request register and the cell match flags
//   to the output register. The controller serves one request at a time
//   through accept, compare and commit; a new request waits for the last commit.
//   Stall: the result register holds its transaction while out_ready is low;
//   the next request is still accepted and compared, and it commits as soon
//   as the waiting result is taken.
//   Reset: the entry count clears at once, so the table is empty; stored keys
//   and values are left as they are and are never read before being written.
`default_nettype none
`include "ordered_key_value_table_macros.svh"

module ordered_key_value_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  action,
	input  wire logic [31:0] key_in,
	input  wire logic [31:0] value_in,
	input  wire logic [3:0]  position_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [31:0]      key_out,
	output logic [31:0]      value_out,
	output logic [3:0]       position_out,
	output logic [4:0]       entry_total
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_RES  = 3'b100
	} state_t;

	state_t                              state_q;
	logic [2:0]                          act_q;
	logic [okvt_pkg::KEY_BITS-1:0]       req_key_q;
	logic [okvt_pkg::VALUE_BITS-1:0]     req_val_q;
	logic [okvt_pkg::IDX_BITS-1:0]       req_pos_q;
	logic [okvt_pkg::CNT_BITS-1:0]       count_q;
	logic [okvt_pkg::CNT_BITS-1:0]       count_nxt;

	logic                                out_valid_q;
	okvt_pkg::status_t                   status_q;
	logic [okvt_pkg::KEY_BITS-1:0]       key_out_q;
	logic [okvt_pkg::VALUE_BITS-1:0]     val_out_q;
	logic [okvt_pkg::IDX_BITS-1:0]       pos_out_q;

	okvt_pkg::status_t                   res_status;
	logic [okvt_pkg::KEY_BITS-1:0]       res_key;
	logic [okvt_pkg::VALUE_BITS-1:0]     res_val;
	logic [okvt_pkg::IDX_BITS-1:0]       res_pos;

	logic                                accept;
	logic                                commit;
	logic                                full;
	okvt_pkg::cell_bus_t                 bus;
	okvt_pkg::sel_res_t                  sel;
	logic [okvt_pkg::CAPACITY-1:0]       match;
	logic [okvt_pkg::KEY_BITS-1:0]       keys   [okvt_pkg::CAPACITY];
	logic [okvt_pkg::VALUE_BITS-1:0]     values [okvt_pkg::CAPACITY];

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign commit   = (state_q == ST_RES) && (!out_valid_q || out_ready);
	assign full     = (count_q == okvt_pkg::CNT_BITS'(okvt_pkg::CAPACITY));

	// Controller sequence: accept, compare, commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_RES;
				ST_RES:  if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request register.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= action;
			req_key_q <= okvt_pkg::key_from_port(key_in);
			req_val_q <= okvt_pkg::value_from_port(value_in);
			req_pos_q <= okvt_pkg::IDX_BITS'(position_in);
		end
	end

	// Result of the request and the commands for the cells.
	always_comb begin
		res_status   = okvt_pkg::STAT_NOT_FOUND;
		res_key      = '0;
		res_val      = '0;
		res_pos      = '0;
		count_nxt    = count_q;
		bus          = '0;
		bus.by_pos   = (act_q == okvt_pkg::ACT_READ);
		bus.pos      = req_pos_q;
		bus.count    = count_q;
		bus.key      = req_key_q;
		bus.value    = req_val_q;
		unique case (act_q)
			okvt_pkg::ACT_LOOKUP, okvt_pkg::ACT_SET: begin
				res_key = req_key_q;
				if (sel.hit) begin
					res_status = okvt_pkg::STAT_HIT;
					res_key    = sel.key;
					res_val    = (act_q == okvt_pkg::ACT_SET) ? req_val_q : sel.value;
					res_pos    = okvt_pkg::IDX_BITS'(sel.pos);
					bus.wr_val = commit && (act_q == okvt_pkg::ACT_SET);
				end else if (full) begin
					res_status = okvt_pkg::STAT_FULL;
				end else begin
					res_status = okvt_pkg::STAT_INSERTED;
					res_val    = (act_q == okvt_pkg::ACT_SET) ? req_val_q : '0;
					res_pos    = okvt_pkg::IDX_BITS'(count_q);
					bus.value  = res_val;
					bus.ins    = commit;
					count_nxt  = count_q + okvt_pkg::CNT_BITS'(1);
				end
			end
			okvt_pkg::ACT_UPDATE: begin
				res_key = req_key_q;
				if (sel.hit) begin
					res_status = okvt_pkg::STAT_HIT;
					res_val    = req_val_q;
					res_pos    = okvt_pkg::IDX_BITS'(sel.pos);
					bus.wr_val = commit;
				end
			end
			okvt_pkg::ACT_DELETE: begin
				res_key = req_key_q;
				if (sel.hit) begin
					res_status   = okvt_pkg::STAT_HIT;
					res_val      = sel.value;
					res_pos      = okvt_pkg::IDX_BITS'(sel.pos);
					bus.shift_en = commit;
					count_nxt    = count_q - okvt_pkg::CNT_BITS'(1);
				end
			end
			okvt_pkg::ACT_CLEAR: begin
				res_status = okvt_pkg::STAT_HIT;
				count_nxt  = '0;
			end
			okvt_pkg::ACT_READ: begin
				res_pos = req_pos_q;
				if (sel.hit) begin
					res_status = okvt_pkg::STAT_HIT;
					res_key    = sel.key;
					res_val    = sel.value;
				end else begin
					res_status = okvt_pkg::STAT_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			count_q <= count_nxt;
		end
	end

	// Output register: loaded on commit, emptied when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q  <= res_status;
			key_out_q <= res_key;
			val_out_q <= res_val;
			pos_out_q <= res_pos;
		end
	end

	// Row of entry cells; on delete, the picked cell and those above it take their upper neighbor's contents.
	for (genvar i = 0; i < okvt_pkg::CAPACITY; i++) begin : g_cell
		logic [okvt_pkg::KEY_BITS-1:0]   nb_key;
		logic [okvt_pkg::VALUE_BITS-1:0] nb_value;

		if (i == okvt_pkg::CAPACITY - 1) begin : g_top
			assign nb_key   = '0;
			assign nb_value = '0;
		end else begin : g_mid
			assign nb_key   = keys[i+1];
			assign nb_value = values[i+1];
		end

		okvt_cell u_cell (
			.clk      (clk),
			.idx      (okvt_pkg::POS_BITS'(i)),
			.bus      (bus),
			.sel      (sel.onehot[i]),
			.after    (sel.after[i]),
			.nb_key   (nb_key),
			.nb_value (nb_value),
			.key_q    (keys[i]),
			.value_q  (values[i]),
			.match_q  (match[i])
		);
	end

	okvt_select u_select (
		.match  (match),
		.keys   (keys),
		.values (values),
		.res    (sel)
	);

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign key_out      = okvt_pkg::key_to_port(key_out_q);
	assign value_out    = okvt_pkg::value_to_port(val_out_q);
	assign position_out = 4'(pos_out_q);
	assign entry_total  = 5'(count_q);

	// Checks on the controller and the cell row.
	`OKVT_ASSERT_SAME(a_count_bound, 1'b1, count_q <= okvt_pkg::CNT_BITS'(okvt_pkg::CAPACITY), "entry count beyond capacity")
	`OKVT_ASSERT_NEXT(a_accept_cmp, accept, state_q == ST_CMP, "accepted transaction did not reach compare")
	`OKVT_ASSERT_NEXT(a_count_hold, !commit, $stable(count_q), "entry count changed without a commit")
	`OKVT_ASSERT_SAME(a_pick_onehot, state_q == ST_RES, $onehot0(sel.onehot), "more than one cell picked")

endmodule

`default_nettype wire
